[hw/rtl/ptrf_pkg.sv]
// Package for the per-thread region trace filter.
// Field widths, configuration register indexes and thread filter modes.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none

package ptrf_pkg;

    localparam int TID_W     = 6;
    localparam int INSTR_W   = 31;
    localparam int PAYLOAD_W = 64;
    localparam int MASK_W    = 64;
    localparam int CNT_W     = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_THREAD_COUNT = 64;
    localparam int DEF_ID_WIDTH     = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THREAD_FILTER_MODE = 3'd0,
        REG_THREAD_LIST_MASK   = 3'd1,
        REG_START_ID_COUNT     = 3'd2,
        REG_START_ID_FIRST     = 3'd3,
        REG_START_ID_SECOND    = 3'd4,
        REG_END_ID_COUNT       = 3'd5,
        REG_END_ID_FIRST       = 3'd6,
        REG_END_ID_SECOND      = 3'd7
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE      = 2'd0,
        MODE_KEEP_ONLY = 2'd1,
        MODE_REMOVE    = 2'd2
    } t_filter_mode;

endpackage

`default_nettype wire

[hw/rtl/ptrf_in_if.sv]
// Input channel of the trace filter: one trace record per item.
// Depends on ptrf_pkg for field widths.
`default_nettype none

interface ptrf_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptrf_pkg::TID_W-1:0]     thread_id;
    logic [ptrf_pkg::INSTR_W-1:0]   instr_id;
    logic [ptrf_pkg::PAYLOAD_W-1:0] payload;

    modport source (output valid, thread_id, instr_id, payload, input ready);
    modport sink   (input valid, thread_id, instr_id, payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/ptrf_out_if.sv]
// Output channel of the trace filter: one passed trace record per item.
// Depends on ptrf_pkg for field widths.
`default_nettype none

interface ptrf_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptrf_pkg::TID_W-1:0]     out_thread_id;
    logic [ptrf_pkg::INSTR_W-1:0]   out_instr_id;
    logic [ptrf_pkg::PAYLOAD_W-1:0] out_payload;

    modport source (output valid, out_thread_id, out_instr_id, out_payload, input ready);
    modport sink   (input valid, out_thread_id, out_instr_id, out_payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/per_thread_region_trace_filter.sv]
// Per-thread region trace filter, top level.
// Depends on ptrf_pkg, ptrf_in_if and ptrf_out_if.
`default_nettype none

// Passes or drops trace records. A record is dropped by the thread filter
// (keep-only or remove against the thread mask) or when its thread is outside
// a region; start and end instruction ids open and close each thread's region,
// end winning when both match. Throughput is one item per cycle with no
// bubbles while the output is not stalled; a passed record goes through the
// registered read of the per-thread region memory and then the output
// register. A write to the same thread in the accept cycle is bypassed into
// the read data. Seen bits are flops cleared by reset, so there is no clearing
// pass and items are taken from the first cycle after reset. Configuration may
// be written only while the block is empty.
module per_thread_region_trace_filter #(
    parameter int THREAD_COUNT = ptrf_pkg::DEF_THREAD_COUNT,
    parameter int ID_WIDTH     = ptrf_pkg::DEF_ID_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ptrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ptrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptrf_in_if.sink                              i_in,
    ptrf_out_if.source                           o_out
);
    import ptrf_pkg::*;

    localparam int TIDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int CMP_W  = (ID_WIDTH < INSTR_W) ? ID_WIDTH : INSTR_W;
    localparam logic [TID_W:0] TC_LIM = (TID_W+1)'(THREAD_COUNT);

    // configuration
    t_filter_mode        r_mode;
    logic [MASK_W-1:0]   r_mask;
    logic [CNT_W-1:0]    r_start_cnt;
    logic [CMP_W-1:0]    r_start_a;
    logic [CMP_W-1:0]    r_start_b;
    logic [CNT_W-1:0]    r_end_cnt;
    logic [CMP_W-1:0]    r_end_a;
    logic [CMP_W-1:0]    r_end_b;

    // stage 1: record waiting on the memory read
    logic                 r_s1_valid;
    logic [TID_W-1:0]     r_s1_tid;
    logic [INSTR_W-1:0]   r_s1_iid;
    logic [PAYLOAD_W-1:0] r_s1_payload;
    logic                 r_rd_q;
    logic                 r_rd_hit;
    logic                 r_rd_byp;

    // output register
    logic                 r_out_valid;
    logic [TID_W-1:0]     r_out_tid;
    logic [INSTR_W-1:0]   r_out_iid;
    logic [PAYLOAD_W-1:0] r_out_payload;

    // per-thread state
    logic [THREAD_COUNT-1:0] r_seen;
    logic                    r_region_mem [THREAD_COUNT];

    logic              out_free;
    logic              in_take;
    logic              s1_go;
    logic [TIDX_W-1:0] in_idx;
    logic [TIDX_W-1:0] s1_idx;
    logic              s1_in_range;
    logic              s1_listed;
    logic              s1_dropped;
    logic              s1_keep;
    logic              s1_prev;
    logic              s1_base;
    logic [CMP_W-1:0]  s1_cid;
    logic              s1_start_hit;
    logic              s1_end_hit;
    logic              n_region;
    logic              s1_emit;
    logic              wr_en;

    // handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;
    assign in_idx     = i_in.thread_id[TIDX_W-1:0];

    // region update for the record in stage 1
    always_comb begin
        s1_idx      = r_s1_tid[TIDX_W-1:0];
        s1_in_range = {1'b0, r_s1_tid} < TC_LIM;
        s1_listed   = r_mask[r_s1_tid];
        case (r_mode)
            MODE_KEEP_ONLY: s1_dropped = !s1_listed;
            MODE_REMOVE:    s1_dropped = s1_listed;
            default:        s1_dropped = 1'b0;
        endcase
        s1_keep = s1_in_range && !s1_dropped;

        s1_prev = r_rd_hit ? r_rd_byp : r_rd_q;
        s1_base = r_seen[s1_idx] ? s1_prev : (r_start_cnt == '0);

        s1_cid       = r_s1_iid[CMP_W-1:0];
        // a count of three acts as two
        s1_start_hit = ((r_start_cnt != '0) && (s1_cid == r_start_a))
                    || (r_start_cnt[1] && (s1_cid == r_start_b));
        s1_end_hit   = ((r_end_cnt != '0) && (s1_cid == r_end_a))
                    || (r_end_cnt[1] && (s1_cid == r_end_b));

        if (s1_end_hit) begin
            n_region = 1'b0;
        end else if (s1_start_hit) begin
            n_region = 1'b1;
        end else begin
            n_region = s1_base;
        end
        s1_emit = s1_keep && n_region;
        wr_en   = s1_go && s1_keep;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_mask      <= '0;
            r_start_cnt <= '0;
            r_start_a   <= '0;
            r_start_b   <= '0;
            r_end_cnt   <= '0;
            r_end_a     <= '0;
            r_end_b     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_THREAD_FILTER_MODE: r_mode      <= t_filter_mode'(i_cfg_data[MODE_W-1:0]);
                REG_THREAD_LIST_MASK:   r_mask      <= i_cfg_data[MASK_W-1:0];
                REG_START_ID_COUNT:     r_start_cnt <= i_cfg_data[CNT_W-1:0];
                REG_START_ID_FIRST:     r_start_a   <= i_cfg_data[CMP_W-1:0];
                REG_START_ID_SECOND:    r_start_b   <= i_cfg_data[CMP_W-1:0];
                REG_END_ID_COUNT:       r_end_cnt   <= i_cfg_data[CNT_W-1:0];
                REG_END_ID_FIRST:       r_end_a     <= i_cfg_data[CMP_W-1:0];
                REG_END_ID_SECOND:      r_end_b     <= i_cfg_data[CMP_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= in_take;
            end
            if (out_free) begin
                r_out_valid <= s1_go && s1_emit;
            end
            if (wr_en) begin
                r_seen[s1_idx] <= 1'b1;
            end
        end
    end

    // region memory: registered read, write from stage 1
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_region_mem[s1_idx] <= n_region;
        end
        if (in_take) begin
            r_rd_q <= r_region_mem[in_idx];
        end
    end

    // payload registers and read bypass
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_tid     <= i_in.thread_id;
            r_s1_iid     <= i_in.instr_id;
            r_s1_payload <= i_in.payload;
            // same thread written in this cycle: take the new value
            r_rd_hit     <= wr_en && (s1_idx == in_idx);
            r_rd_byp     <= n_region;
        end
        if (s1_go && out_free) begin
            r_out_tid     <= r_s1_tid;
            r_out_iid     <= r_s1_iid;
            r_out_payload <= r_s1_payload;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_thread_id = r_out_tid;
    assign o_out.out_instr_id  = r_out_iid;
    assign o_out.out_payload   = r_out_payload;

    // a thread that passed the filter is marked seen
    a_seen_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_seen[$past(s1_idx)])
        else $error("seen bit not set after region update");

    // an emitted record reaches the output register
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_emit) |=> r_out_valid)
        else $error("emitted record lost before output register");

    // output register and stage 1 are empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[test/ptrf_record_checker.sv]
// Checker for the per-thread region trace filter: mirrors the registers and the
// per-thread seen and in-region bits, predicts which records pass, compares outputs.
// Depends on ptrf_pkg, ptrf_in_if and ptrf_out_if.
`timescale 1ns / 100ps

module ptrf_record_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ptrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ptrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptrf_in_if                                   i_in,
    ptrf_out_if                                  i_out,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);

    import ptrf_pkg::*;

    typedef struct packed {
        logic [TID_W-1:0]     tid;
        logic [INSTR_W-1:0]   iid;
        logic [PAYLOAD_W-1:0] pl;
    } t_trace_rec;

    t_trace_rec passed_rec_q[$];

    // register mirror
    logic [MODE_W-1:0]  filt_mode;
    logic [MASK_W-1:0]  thread_mask;
    logic [CNT_W-1:0]   start_cnt;
    logic [INSTR_W-1:0] start_a;
    logic [INSTR_W-1:0] start_b;
    logic [CNT_W-1:0]   end_cnt;
    logic [INSTR_W-1:0] end_a;
    logic [INSTR_W-1:0] end_b;

    logic [DEF_THREAD_COUNT-1:0] seen;
    logic [DEF_THREAD_COUNT-1:0] in_region;

    function automatic logic thread_blocked(input logic [TID_W-1:0] tid);
        logic listed;
        listed = thread_mask[tid];
        if (filt_mode == MODE_KEEP_ONLY)
            return !listed;
        if (filt_mode == MODE_REMOVE)
            return listed;
        return 1'b0;
    endfunction

    // a count of three behaves as two
    function automatic logic id_hit(input logic [INSTR_W-1:0] iid,
                                    input logic [CNT_W-1:0] cnt,
                                    input logic [INSTR_W-1:0] a,
                                    input logic [INSTR_W-1:0] b);
        return (cnt >= 2'd1 && iid == a) || (cnt >= 2'd2 && iid == b);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_trace_rec got;
        t_trace_rec want;
        logic [TID_W-1:0] t;
        if (!i_rst_n) begin
            filt_mode   = '0;
            thread_mask = '0;
            start_cnt   = '0;
            start_a     = '0;
            start_b     = '0;
            end_cnt     = '0;
            end_a       = '0;
            end_b       = '0;
            seen        = '0;
            in_region   = '0;
            passed_rec_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_THREAD_FILTER_MODE: filt_mode   = i_cfg_data[MODE_W-1:0];
                    REG_THREAD_LIST_MASK:   thread_mask = i_cfg_data[MASK_W-1:0];
                    REG_START_ID_COUNT:     start_cnt   = i_cfg_data[CNT_W-1:0];
                    REG_START_ID_FIRST:     start_a     = i_cfg_data[INSTR_W-1:0];
                    REG_START_ID_SECOND:    start_b     = i_cfg_data[INSTR_W-1:0];
                    REG_END_ID_COUNT:       end_cnt     = i_cfg_data[CNT_W-1:0];
                    REG_END_ID_FIRST:       end_a       = i_cfg_data[INSTR_W-1:0];
                    REG_END_ID_SECOND:      end_b       = i_cfg_data[INSTR_W-1:0];
                    default: ;
                endcase
            end

            if (i_out.valid && i_out.ready) begin
                got = '{i_out.out_thread_id, i_out.out_instr_id, i_out.out_payload};
                if (passed_rec_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected record tid=%0d iid=%h payload=%h",
                                 $realtime, got.tid, got.iid, got.pl);
                    o_fail_count++;
                end else begin
                    want = passed_rec_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch exp %0d/%h/%h got %0d/%h/%h",
                                     $realtime, want.tid, want.iid, want.pl,
                                     got.tid, got.iid, got.pl);
                        o_fail_count++;
                    end
                    o_checked++;
                end
            end

            if (i_in.valid && i_in.ready) begin
                t = i_in.thread_id;
                // a filtered record leaves the thread state alone
                if (!thread_blocked(t)) begin
                    if (!seen[t]) begin
                        seen[t]      = 1'b1;
                        in_region[t] = (start_cnt == 2'd0);
                    end
                    if (id_hit(i_in.instr_id, start_cnt, start_a, start_b))
                        in_region[t] = 1'b1;
                    if (id_hit(i_in.instr_id, end_cnt, end_a, end_b))
                        in_region[t] = 1'b0;
                    if (in_region[t])
                        passed_rec_q.push_back('{t, i_in.instr_id, i_in.payload});
                end
            end
        end
        o_pending = passed_rec_q.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top for the per-thread region trace filter: clock, reset, register
// writes, record stimulus with random idling, output back-pressure, watchdog and verdict.
// Depends on ptrf_pkg, the channel interfaces, the block and ptrf_record_checker.
`timescale 1ns / 100ps

module tb_top;

    import ptrf_pkg::*;

    localparam int                IDLE_LIMIT   = 2000;
    localparam int                PHASE_ITEMS  = 192;
    localparam int                RAND_PHASES  = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptrf_in_if  in_ch ();
    ptrf_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int records_sent;
    int settings_used;
    int idle_cycles;
    bit steady;

    // current region ids, used to aim instruction ids at them
    logic [INSTR_W-1:0] cur_s1, cur_s2, cur_e1, cur_e2;

    per_thread_region_trace_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    ptrf_record_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return rand64();
    endfunction

    function automatic logic [INSTR_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return INSTR_W'($urandom);
    endfunction

    // instruction ids biased towards the region ids so regions open and close often
    function automatic logic [INSTR_W-1:0] aim_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return cur_s1;
        if (r < 32)
            return cur_s2;
        if (r < 42)
            return cur_e1;
        if (r < 50)
            return cur_e2;
        return INSTR_W'($urandom);
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic apply_setting(input logic [MODE_W-1:0] mode,
                                 input logic [MASK_W-1:0] mask,
                                 input logic [CNT_W-1:0] sc,
                                 input logic [INSTR_W-1:0] s1,
                                 input logic [INSTR_W-1:0] s2,
                                 input logic [CNT_W-1:0] ec,
                                 input logic [INSTR_W-1:0] e1,
                                 input logic [INSTR_W-1:0] e2);
        write_reg(REG_THREAD_FILTER_MODE, 64'(mode));
        write_reg(REG_THREAD_LIST_MASK, mask);
        write_reg(REG_START_ID_COUNT, 64'(sc));
        write_reg(REG_START_ID_FIRST, 64'(s1));
        write_reg(REG_START_ID_SECOND, 64'(s2));
        write_reg(REG_END_ID_COUNT, 64'(ec));
        write_reg(REG_END_ID_FIRST, 64'(e1));
        write_reg(REG_END_ID_SECOND, 64'(e2));
        cur_s1 = s1;
        cur_s2 = s2;
        cur_e1 = e1;
        cur_e2 = e2;
        settings_used++;
    endtask

    task automatic send_record(input logic [TID_W-1:0] tid,
                               input logic [INSTR_W-1:0] iid,
                               input logic [PAYLOAD_W-1:0] pl);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.thread_id = tid;
        in_ch.instr_id  = iid;
        in_ch.payload   = pl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        records_sent++;
    endtask

    // drain the pipe; dropped items may still be in flight, hence the extra cycles
    task automatic quiesce();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.thread_id = '0;
        in_ch.instr_id  = '0;
        in_ch.payload   = '0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        steady          = 1'b0;
        records_sent    = 0;
        settings_used   = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // output side back-pressure
    initial begin : sink_side
        int run;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = $urandom_range(1, 12);
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            repeat (run - 1) @(negedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  sc;
        logic [CNT_W-1:0]  ec;
        logic [TID_W-1:0]  tid;
        @(posedge i_rst_n);

        // remove mode, counts of three, an id that both opens and closes
        apply_setting(MODE_REMOVE, 64'h20, 2'd3, 31'h100, '1, 2'd3, '1, '0);
        send_record(6'd0, 31'h55, '0);          // first sight with starts in use: closed
        send_record(6'd0, 31'h100, '1);         // opens
        send_record(6'd0, 31'h1234, rand64());
        send_record(6'd0, '1, rand64());        // start and end both match, end wins
        send_record(6'd0, 31'h200, rand64());
        send_record(6'd63, 31'h100, rand64());
        send_record(6'd63, '0, rand64());       // second end id closes
        send_record(6'd5, 31'h100, rand64());   // removed thread
        send_record(6'd63, 31'h100, rand64());

        // unused mode behaves as no filter; no start ids so new threads open at once
        quiesce();
        apply_setting(MODE_UNUSED, '1, 2'd0, '0, '0, 2'd1, 31'h3ff, '0);
        send_record(6'd5, 31'h77, rand64());
        send_record(6'd5, 31'h3ff, rand64());
        send_record(6'd5, '0, rand64());
        send_record(6'd1, '0, rand64());        // second end id not in use
        send_record(6'd63, 31'h55, rand64());

        quiesce();
        apply_setting(MODE_KEEP_ONLY, 64'h8000_0000_0000_0002, 2'd1, '0, '0, 2'd0, '0, '0);
        send_record(6'd0, '0, rand64());
        send_record(6'd1, 31'h3ff, rand64());
        send_record(6'd2, '0, rand64());
        send_record(6'd63, '1, '0);

        quiesce();
        apply_setting(MODE_NONE, '0, 2'd2, 31'h10, 31'h20, 2'd2, 31'h30, 31'h40);
        send_record(6'd2, 31'h5, rand64());
        send_record(6'd2, 31'h20, rand64());
        send_record(6'd2, 31'h40, rand64());
        send_record(6'd2, 31'h10, rand64());
        send_record(6'd2, 31'h30, rand64());
        send_record(6'd0, 31'h10, rand64());

        for (int p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            mode   = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
            sc     = CNT_W'(p % 4);
            ec     = CNT_W'(3 - (p % 4));
            steady = (p == 2 || p == 5);
            apply_setting(mode, pick_mask(), sc, pick_id(), pick_id(), ec, pick_id(), pick_id());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // half the records come from a few hot threads
                tid = $urandom_range(0, 1) ? TID_W'($urandom_range(0, 63))
                                           : TID_W'($urandom_range(0, 7));
                send_record(tid, aim_id(), rand64());
            end
        end
        steady = 1'b0;

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        $display("Summary: %0d records sent under %0d register settings,",
                 records_sent, settings_used);
        $display("         %0d passed records checked", checked);
        if (fail_count == 0 && pending == 0)
            $display("per_thread_region_trace_filter test passed");
        else
            $display("per_thread_region_trace_filter test failed");
        $finish;
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("per_thread_region_trace_filter test failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

[per_thread_region_trace_filter.f]
hw/rtl/ptrf_pkg.sv
hw/rtl/ptrf_in_if.sv
hw/rtl/ptrf_out_if.sv
hw/rtl/per_thread_region_trace_filter.sv
test/ptrf_record_checker.sv
test/tb_top.sv
